// ===== rtl/rrss_pkg.sv =====
// shared types and constants for the round-robin slot scheduler
`timescale 1ns / 1ps
package rrss_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int TIME_WIDTH  = 32;
	localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
	localparam int SLOT_CODE_W = $clog2(NUM_SLOTS + 1);
	localparam logic [SLOT_CODE_W-1:0] SLOT_NONE = SLOT_CODE_W'(NUM_SLOTS);
	localparam logic [7:0] QUANTUM_RESET = 8'd10;

	// op codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_YIELD = 3'd1;
	localparam logic [2:0] OP_SLEEP = 3'd2;
	localparam logic [2:0] OP_SPAWN = 3'd3;
	localparam logic [2:0] OP_EXIT  = 3'd4;
	localparam logic [2:0] OP_REAP  = 3'd5;

	typedef enum logic [2:0] {
		SS_FREE     = 3'd0,
		SS_RUNNABLE = 3'd1,
		SS_RUNNING  = 3'd2,
		SS_SLEEPING = 3'd3,
		SS_ZOMBIE   = 3'd4
	} slot_st_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_COMMIT
	} fsm_st_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        user_mode;
		logic [31:0] sleep_ticks;
		logic [3:0]  reap_slot;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_CODE_W-1:0] current_slot;
		logic                   switched;
		logic [SLOT_CODE_W-1:0] spawned_slot;
		logic                   wait_in_place;
		logic                   reaped;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage

// ===== rtl/rrss_ctrl.sv =====
// controller state machine: accept, scan the slot table, commit the result
`timescale 1ns / 1ps
module rrss_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  rrss_pkg::dp_status_t status,
	output rrss_pkg::ctrl_cmd_t  cmd
);

	rrss_pkg::fsm_st_t state_q, state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == rrss_pkg::FSM_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrss_pkg::FSM_IDLE: begin
				if (in_valid) state_d = rrss_pkg::FSM_SCAN;
			end
			rrss_pkg::FSM_SCAN: begin
				if (status.scan_last) state_d = rrss_pkg::FSM_COMMIT;
			end
			rrss_pkg::FSM_COMMIT: begin
				if (out_free) state_d = rrss_pkg::FSM_IDLE;
			end
			default: state_d = rrss_pkg::FSM_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			rrss_pkg::FSM_IDLE:   cmd.start  = in_valid;
			rrss_pkg::FSM_SCAN:   cmd.scan   = 1'b1;
			rrss_pkg::FSM_COMMIT: cmd.commit = out_free;
			default:              cmd        = '0;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrss_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/rrss_dp.sv =====
// datapath: slot table, wake times, scan results, commit logic, result register
`timescale 1ns / 1ps
module rrss_dp #(
	parameter int TIME_W = rrss_pkg::TIME_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrss_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data,
	input  rrss_pkg::ctrl_cmd_t  cmd,
	output rrss_pkg::dp_status_t status,
	output rrss_pkg::out_item_t  out_data
);

	localparam int N  = rrss_pkg::NUM_SLOTS;
	localparam int IW = rrss_pkg::SLOT_IDX_W;
	localparam int CW = rrss_pkg::SLOT_CODE_W;

	rrss_pkg::slot_st_t  slot_q [N];
	logic [TIME_W-1:0]   wake_q [N];
	rrss_pkg::in_item_t  item_q;
	rrss_pkg::out_item_t out_q;
	logic [7:0]          tq_q, qleft_q;
	logic [TIME_W-1:0]   tick_q;
	logic [CW-1:0]       run_q;
	logic [IW-1:0]       idx_q;

	// scan results
	logic          low_vld_q, abv_vld_q, free_vld_q, zomb_q;
	logic [IW-1:0] low_q, abv_q, free_q;
	logic [1:0]    live_q;

	logic               have, is_tick, due, rsl_ok;
	logic [IW-1:0]      run_idx, from_idx, rsl_idx;
	rrss_pkg::slot_st_t cur, eff;

	assign have     = (run_q != rrss_pkg::SLOT_NONE);
	assign run_idx  = run_q[IW-1:0];
	assign from_idx = have ? run_idx : '0;
	assign is_tick  = (item_q.op == rrss_pkg::OP_TICK);
	assign rsl_ok   = (32'(item_q.reap_slot) < N);
	assign rsl_idx  = IW'(item_q.reap_slot);
	assign status.scan_last = (32'(idx_q) == N - 1);
	assign out_data = out_q;

	// current scan entry, with a due sleeper seen as runnable
	assign cur = slot_q[idx_q];
	assign due = is_tick && (cur == rrss_pkg::SS_SLEEPING) && (tick_q >= wake_q[idx_q]);
	assign eff = due ? rrss_pkg::SS_RUNNABLE : cur;

	// commit decisions
	logic               nxt_vld, sw, old_en, spawn_en, reap_en, waitp, wake_we;
	logic [IW-1:0]      nxt, tgt;
	rrss_pkg::slot_st_t old_val;
	logic [7:0]         q_nxt, q_dec;
	logic [CW-1:0]      run_nxt;

	assign nxt_vld = abv_vld_q || low_vld_q;
	assign nxt     = abv_vld_q ? abv_q : low_q;
	assign q_dec   = (qleft_q != 8'd0) ? qleft_q - 8'd1 : 8'd0;

	always_comb begin
		sw       = 1'b0;
		tgt      = nxt;
		old_en   = 1'b0;
		old_val  = rrss_pkg::SS_RUNNABLE;
		spawn_en = 1'b0;
		reap_en  = 1'b0;
		waitp    = 1'b0;
		wake_we  = 1'b0;
		q_nxt    = qleft_q;
		run_nxt  = run_q;
		case (item_q.op)
			rrss_pkg::OP_TICK: begin
				if (!have) begin
					sw  = low_vld_q;
					tgt = low_q;
				end else if (item_q.user_mode && live_q == 2'd2) begin
					if (q_dec != 8'd0) q_nxt = q_dec;
					else if (!nxt_vld) q_nxt = tq_q;
					else begin
						old_en = 1'b1;
						sw     = 1'b1;
					end
				end
			end
			rrss_pkg::OP_YIELD: begin
				if (have && nxt_vld) begin
					old_en = 1'b1;
					sw     = 1'b1;
				end
			end
			rrss_pkg::OP_SLEEP: begin
				if (have && item_q.sleep_ticks != 32'd0) begin
					wake_we = 1'b1;
					if (!nxt_vld) waitp = 1'b1;
					else begin
						old_en  = 1'b1;
						old_val = rrss_pkg::SS_SLEEPING;
						sw      = 1'b1;
					end
				end
			end
			rrss_pkg::OP_SPAWN: spawn_en = free_vld_q;
			rrss_pkg::OP_EXIT: begin
				old_en  = have;
				old_val = rrss_pkg::SS_ZOMBIE;
				run_nxt = rrss_pkg::SLOT_NONE;
				sw      = nxt_vld;
			end
			rrss_pkg::OP_REAP: reap_en = zomb_q;
			default: ;
		endcase
		if (sw) begin
			run_nxt = CW'(tgt);
			q_nxt   = tq_q;
		end
	end

	// slot table, one register per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < N; j++) slot_q[j] <= rrss_pkg::SS_FREE;
		end else begin
			for (int j = 0; j < N; j++) begin
				if (cmd.scan && due && idx_q == IW'(j))
					slot_q[j] <= rrss_pkg::SS_RUNNABLE;
				else if (cmd.commit) begin
					if (sw && tgt == IW'(j)) slot_q[j] <= rrss_pkg::SS_RUNNING;
					else if (old_en && run_idx == IW'(j)) slot_q[j] <= old_val;
					else if (spawn_en && free_q == IW'(j)) slot_q[j] <= rrss_pkg::SS_RUNNABLE;
					else if (reap_en && rsl_idx == IW'(j)) slot_q[j] <= rrss_pkg::SS_FREE;
				end
			end
		end
	end

	// wake times, written only by sleep
	always_ff @(posedge clk) begin
		if (cmd.commit && wake_we)
			wake_q[run_idx] <= tick_q + TIME_W'(item_q.sleep_ticks);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tq_q    <= rrss_pkg::QUANTUM_RESET;
			qleft_q <= 8'd0;
			tick_q  <= '0;
			run_q   <= rrss_pkg::SLOT_NONE;
			idx_q   <= '0;
		end else begin
			if (cfg_we) tq_q <= cfg_data;
			if (cmd.start && in_data.op == rrss_pkg::OP_TICK) tick_q <= tick_q + 1'b1;
			if (cmd.start) idx_q <= '0;
			else if (cmd.scan) idx_q <= idx_q + 1'b1;
			if (cmd.commit) begin
				qleft_q <= q_nxt;
				run_q   <= run_nxt;
			end
		end
	end

	// input item capture and scan accumulation
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q     <= in_data;
			low_vld_q  <= 1'b0;
			abv_vld_q  <= 1'b0;
			free_vld_q <= 1'b0;
			zomb_q     <= 1'b0;
			live_q     <= 2'd0;
			low_q      <= '0;
			abv_q      <= '0;
			free_q     <= '0;
		end else if (cmd.scan) begin
			if (eff == rrss_pkg::SS_RUNNABLE) begin
				if (!low_vld_q) begin
					low_vld_q <= 1'b1;
					low_q     <= idx_q;
				end
				if (!abv_vld_q && idx_q > from_idx) begin
					abv_vld_q <= 1'b1;
					abv_q     <= idx_q;
				end
			end
			if ((eff == rrss_pkg::SS_RUNNABLE || eff == rrss_pkg::SS_RUNNING)
				&& live_q != 2'd2)
				live_q <= live_q + 2'd1;
			if (eff == rrss_pkg::SS_FREE && idx_q != '0 && !free_vld_q) begin
				free_vld_q <= 1'b1;
				free_q     <= idx_q;
			end
			if (rsl_ok && idx_q == rsl_idx && eff == rrss_pkg::SS_ZOMBIE)
				zomb_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.current_slot  <= run_nxt;
			out_q.switched      <= sw;
			out_q.spawned_slot  <= spawn_en ? CW'(free_q) : rrss_pkg::SLOT_NONE;
			out_q.wait_in_place <= waitp;
			out_q.reaped        <= reap_en;
		end
	end

endmodule

// ===== rtl/round_robin_slot_scheduler.sv =====
// Round-robin slot scheduler with a time quantum (top level).
// Usage:
//  - in channel (in_valid/in_ready/in_data) takes one op item: tick, yield,
//    sleep, spawn, exit or reap, with user_mode, sleep_ticks and reap_slot.
//  - out channel (out_valid/out_ready/out_data) returns one result item per
//    op: running slot, switch flag, spawned slot, wait flag, reap flag.
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes the time quantum;
//    it is always ready and should be written only while the block is idle.
// Timing: an item is taken in idle, then the controller walks the slot
// table one slot per cycle and commits once the output register is free;
// the result is then valid and a new item can be taken in the cycle after
// the commit. No new item is taken before the last one has been committed.
// Reset: all slots free, no running slot, tick count and quantum left zero,
// time quantum 10. Wake times are undefined until a sleep writes them.
// Stall: a result waits in the output register; the next item is accepted
// and scanned meanwhile, and its commit waits until the result is taken.
`timescale 1ns / 1ps
module round_robin_slot_scheduler #(
	parameter int TIME_WIDTH = rrss_pkg::TIME_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrss_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rrss_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	rrss_pkg::ctrl_cmd_t  cmd;
	rrss_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	// controller
	rrss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	rrss_dp #(
		.TIME_W (TIME_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

// ===== dv/rrss_checker.sv =====
// scoreboard for the slot scheduler: watches the channels, predicts each result and compares
`timescale 1ns / 1ps
module rrss_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  rrss_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  rrss_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen
);

	// shadow copy of the scheduler state
	rrss_pkg::slot_st_t                tbl_st [rrss_pkg::NUM_SLOTS];
	logic [rrss_pkg::TIME_WIDTH-1:0]   tbl_wake [rrss_pkg::NUM_SLOTS];
	logic [rrss_pkg::SLOT_CODE_W-1:0]  cur_slot;
	logic [7:0]                        quantum_cfg;
	logic [7:0]                        quantum_rem;
	logic [rrss_pkg::TIME_WIDTH-1:0]   ticks_now;
	rrss_pkg::out_item_t               result_q [$];

	function automatic logic [rrss_pkg::SLOT_CODE_W-1:0] next_ready_after(input int from);
		int s;
		for (int i = 1; i <= rrss_pkg::NUM_SLOTS; i++) begin
			s = (from + i) % rrss_pkg::NUM_SLOTS;
			if (tbl_st[s] == rrss_pkg::SS_RUNNABLE)
				return rrss_pkg::SLOT_CODE_W'(s);
		end
		return rrss_pkg::SLOT_NONE;
	endfunction

	function automatic int live_slots();
		int n;
		n = 0;
		for (int i = 0; i < rrss_pkg::NUM_SLOTS; i++)
			if (tbl_st[i] == rrss_pkg::SS_RUNNING || tbl_st[i] == rrss_pkg::SS_RUNNABLE)
				n++;
		return n;
	endfunction

	function automatic void start_slot(input logic [rrss_pkg::SLOT_CODE_W-1:0] s);
		tbl_st[s] = rrss_pkg::SS_RUNNING;
		cur_slot = s;
		quantum_rem = quantum_cfg;
	endfunction

	// one op against the shadow state, giving its result item
	function automatic rrss_pkg::out_item_t schedule_op(input rrss_pkg::in_item_t it);
		rrss_pkg::out_item_t r;
		logic have;
		logic [rrss_pkg::SLOT_CODE_W-1:0] nxt;
		r = '0;
		r.spawned_slot = rrss_pkg::SLOT_NONE;
		have = (cur_slot != rrss_pkg::SLOT_NONE);
		case (it.op)
			rrss_pkg::OP_TICK: begin
				ticks_now = ticks_now + 1'b1;
				for (int i = 0; i < rrss_pkg::NUM_SLOTS; i++)
					if (tbl_st[i] == rrss_pkg::SS_SLEEPING && ticks_now >= tbl_wake[i])
						tbl_st[i] = rrss_pkg::SS_RUNNABLE;
				if (!have) begin
					for (int i = 0; i < rrss_pkg::NUM_SLOTS; i++)
						if (tbl_st[i] == rrss_pkg::SS_RUNNABLE && !r.switched) begin
							start_slot(rrss_pkg::SLOT_CODE_W'(i));
							r.switched = 1'b1;
						end
				end else if (it.user_mode && live_slots() >= 2) begin
					if (quantum_rem > 0)
						quantum_rem--;
					if (quantum_rem == 0) begin
						nxt = next_ready_after(cur_slot);
						if (nxt == rrss_pkg::SLOT_NONE) begin
							quantum_rem = quantum_cfg;
						end else begin
							tbl_st[cur_slot] = rrss_pkg::SS_RUNNABLE;
							start_slot(nxt);
							r.switched = 1'b1;
						end
					end
				end
			end
			rrss_pkg::OP_YIELD: begin
				if (have) begin
					nxt = next_ready_after(cur_slot);
					if (nxt != rrss_pkg::SLOT_NONE) begin
						tbl_st[cur_slot] = rrss_pkg::SS_RUNNABLE;
						start_slot(nxt);
						r.switched = 1'b1;
					end
				end
			end
			rrss_pkg::OP_SLEEP: begin
				if (have && it.sleep_ticks != 0) begin
					tbl_wake[cur_slot] = ticks_now + it.sleep_ticks;
					nxt = next_ready_after(cur_slot);
					if (nxt == rrss_pkg::SLOT_NONE) begin
						r.wait_in_place = 1'b1;
					end else begin
						tbl_st[cur_slot] = rrss_pkg::SS_SLEEPING;
						start_slot(nxt);
						r.switched = 1'b1;
					end
				end
			end
			rrss_pkg::OP_SPAWN: begin
				for (int i = 1; i < rrss_pkg::NUM_SLOTS; i++)
					if (tbl_st[i] == rrss_pkg::SS_FREE
						&& r.spawned_slot == rrss_pkg::SLOT_NONE) begin
						tbl_st[i] = rrss_pkg::SS_RUNNABLE;
						r.spawned_slot = rrss_pkg::SLOT_CODE_W'(i);
					end
			end
			rrss_pkg::OP_EXIT: begin
				if (have)
					tbl_st[cur_slot] = rrss_pkg::SS_ZOMBIE;
				nxt = next_ready_after(have ? int'(cur_slot) : 0);
				cur_slot = rrss_pkg::SLOT_NONE;
				if (nxt != rrss_pkg::SLOT_NONE) begin
					start_slot(nxt);
					r.switched = 1'b1;
				end
			end
			rrss_pkg::OP_REAP: begin
				if (tbl_st[it.reap_slot] == rrss_pkg::SS_ZOMBIE) begin
					tbl_st[it.reap_slot] = rrss_pkg::SS_FREE;
					r.reaped = 1'b1;
				end
			end
			default: ;
		endcase
		r.current_slot = cur_slot;
		return r;
	endfunction

	assign pending = result_q.size();

	// predict on accepted items, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		rrss_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < rrss_pkg::NUM_SLOTS; i++) begin
				tbl_st[i] = rrss_pkg::SS_FREE;
				tbl_wake[i] = '0;
			end
			cur_slot = rrss_pkg::SLOT_NONE;
			quantum_cfg = rrss_pkg::QUANTUM_RESET;
			quantum_rem = '0;
			ticks_now = '0;
			result_q.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				quantum_cfg = cfg_data;
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (result_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (want !== out_data) begin
						if (fail_count < 10)
							$display("mismatch: expected %p got %p", want, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(schedule_op(in_data));
		end
	end
endmodule

// ===== dv/tb_top.sv =====
// stimulus and verdict for the round-robin slot scheduler
`timescale 1ns / 1ps
module tb_top;

	localparam int LIMIT = 2000000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	rrss_pkg::in_item_t  in_data;
	rrss_pkg::out_item_t out_data;
	logic [7:0] cfg_data;
	int fail_count, pending, results_seen;
	int idle_pct, stall_pct, items_sent, cycles;
	logic hold_off;

	round_robin_slot_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	rrss_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// valid drops only in idle cycles or in drain, so one assignment per edge
	task automatic send_op(input rrss_pkg::in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic op_item(input logic [2:0] op, input logic um,
			input logic [31:0] nt, input logic [3:0] rs);
		rrss_pkg::in_item_t it;
		it.op = op;
		it.user_mode = um;
		it.sleep_ticks = nt;
		it.reap_slot = rs;
		send_op(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_quantum(input logic [7:0] q);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= q;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random op, weighted towards ticks and a busy table
	task automatic random_op();
		rrss_pkg::in_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.user_mode = $urandom_range(99) < 80;
		it.reap_slot = $urandom_range(15);
		case ($urandom_range(3))
			0: it.sleep_ticks = $urandom_range(8);
			1: it.sleep_ticks = $urandom_range(60);
			2: it.sleep_ticks = $urandom();
			default: it.sleep_ticks = 32'hFFFF_FFFF - $urandom_range(3);
		endcase
		if (pick < 45)      it.op = rrss_pkg::OP_TICK;
		else if (pick < 55) it.op = rrss_pkg::OP_YIELD;
		else if (pick < 67) it.op = rrss_pkg::OP_SLEEP;
		else if (pick < 79) it.op = rrss_pkg::OP_SPAWN;
		else if (pick < 88) it.op = rrss_pkg::OP_EXIT;
		else if (pick < 97) it.op = rrss_pkg::OP_REAP;
		else                it.op = 3'($urandom_range(6, 7));
		send_op(it);
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_off = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, spawns, sleeps, exits, reaps and odd codes
		op_item(rrss_pkg::OP_YIELD, 1'b1, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_SLEEP, 1'b1, 32'd5, 4'd0);
		op_item(rrss_pkg::OP_EXIT, 1'b0, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_TICK, 1'b1, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_SPAWN, 1'b0, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_TICK, 1'b0, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_SLEEP, 1'b0, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_SLEEP, 1'b0, 32'd3, 4'd0);
		op_item(rrss_pkg::OP_SPAWN, 1'b0, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_SLEEP, 1'b1, 32'hFFFF_FFFF, 4'd15);
		op_item(rrss_pkg::OP_EXIT, 1'b1, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_TICK, 1'b1, 32'd0, 4'd0);
		op_item(rrss_pkg::OP_REAP, 1'b0, 32'd0, 4'd2);
		op_item(rrss_pkg::OP_REAP, 1'b0, 32'd0, 4'd15);
		op_item(3'd6, 1'b1, 32'h5555_5555, 4'd5);
		op_item(3'd7, 1'b0, 32'hAAAA_AAAA, 4'd10);
		for (int i = 0; i < 16; i++)
			op_item(rrss_pkg::OP_SPAWN, 1'b0, 32'd0, 4'd0);

		// random phases across quantum settings and idling mixes
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_quantum(8'd1);
				2: set_quantum(8'd255);
				4: set_quantum(8'd0);
				6: set_quantum(8'($urandom_range(2, 6)));
				default: ;
			endcase
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			for (int n = 0; n < 150; n++)
				random_op();
			if (ph == 3) begin
				// sender pauses until every result is back
				drain();
			end
			if (ph == 5) begin
				// long receiver hold-off while items keep coming
				hold_off <= 1'b1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_off <= 1'b0;
					end
					for (int n = 0; n < 10; n++)
						random_op();
				join
			end
		end

		drain();
		$display("ran %0d ops, %0d results checked, quantum 0/1/255 and random",
			items_sent, results_seen);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
